// ----- sv/double_buffer_capture_uplink_ctrl_defines.svh -----
// Assertion macros used by the capture and uplink controller core.
`ifndef DOUBLE_BUFFER_CAPTURE_UPLINK_CTRL_DEFINES_SVH
`define DOUBLE_BUFFER_CAPTURE_UPLINK_CTRL_DEFINES_SVH

// Checks a consequence in the same cycle as its antecedent.
`define DBCU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks a consequence in the cycle after its antecedent.
`define DBCU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/dbcu_pkg.sv -----
// Shared types and constants of the capture and uplink controller.
package dbcu_pkg;

  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ACK_CODE   = 2'd0,
    CFG_IMAGE_COLS = 2'd1,
    CFG_IMAGE_ROWS = 2'd2,
    CFG_BODY_LEN   = 2'd3
  } cfg_idx_t;

  localparam logic [CFG_W-1:0] ACK_CODE_RST   = 8'd6;
  localparam logic [CFG_W-1:0] IMAGE_COLS_RST = 8'd40;
  localparam logic [CFG_W-1:0] IMAGE_ROWS_RST = 8'd40;
  localparam logic [CFG_W-1:0] BODY_LEN_RST   = 8'd4;

  typedef enum logic [2:0] {
    UP_INIT       = 3'd0,
    UP_CONFIG     = 3'd1,
    UP_CONFIG_ACK = 3'd2,
    UP_IMAGE      = 3'd3,
    UP_IMAGE_ACK  = 3'd4,
    UP_SENT       = 3'd5
  } uplink_state_t;

  typedef enum logic [1:0] {
    CAP_INACTIVE  = 2'd0,
    CAP_IDLE      = 2'd1,
    CAP_CAPTURING = 2'd2
  } capture_state_t;

  typedef enum logic [2:0] {
    SEND_NONE     = 3'd0,
    SEND_CFG_HDR  = 3'd1,
    SEND_CFG_BODY = 3'd2,
    SEND_IMG_HDR  = 3'd3,
    SEND_IMG_DATA = 3'd4
  } send_kind_t;

  typedef struct packed {
    logic [CFG_W-1:0] ack_code;
    logic [CFG_W-1:0] image_cols;
    logic [CFG_W-1:0] image_rows;
    logic [CFG_W-1:0] body_len;
  } cfg_regs_t;

  typedef struct packed {
    logic       sensing_enable;
    logic       link_busy;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       capture_done;
  } tick_t;

  typedef struct packed {
    send_kind_t     send_kind;
    logic           send_buffer;
    logic [15:0]    header_length;
    logic           rx_consume;
    logic           launch_capture;
    logic           capture_buffer;
    uplink_state_t  uplink_phase;
    capture_state_t capture_phase;
    logic [1:0]     buffers_full;
  } result_t;

endpackage

// ----- sv/dbcu_cfg_regs.sv -----
// Configuration register file with reset values and indexed writes.
module dbcu_cfg_regs (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [dbcu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [dbcu_pkg::CFG_W-1:0]          cfg_wdata,
  output dbcu_pkg::cfg_regs_t                 cfg
);
  import dbcu_pkg::*;

  cfg_regs_t cfg_r;
  cfg_regs_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ACK_CODE:   cfg_nxt.ack_code   = cfg_wdata;
        CFG_IMAGE_COLS: cfg_nxt.image_cols = cfg_wdata;
        CFG_IMAGE_ROWS: cfg_nxt.image_rows = cfg_wdata;
        CFG_BODY_LEN:   cfg_nxt.body_len   = cfg_wdata;
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ack_code   <= ACK_CODE_RST;
      cfg_r.image_cols <= IMAGE_COLS_RST;
      cfg_r.image_rows <= IMAGE_ROWS_RST;
      cfg_r.body_len   <= BODY_LEN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ----- sv/dbcu_in_stage.sv -----
// Input register stage that holds one control tick until the core takes it.
module dbcu_in_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  dbcu_pkg::tick_t in_tick,
  input  logic            advance,
  output logic            tick_valid,
  output dbcu_pkg::tick_t tick
);
  import dbcu_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  tick_t tick_r;
  logic  load;

  assign load     = !valid_r || advance;
  assign in_stall = !load;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      tick_r <= in_tick;
    end
  end

  assign tick_valid = valid_r;
  assign tick       = tick_r;

endmodule

// ----- sv/dbcu_ctrl_core.sv -----
// Uplink and capture state machines with the shared buffer full flags.
`include "double_buffer_capture_uplink_ctrl_defines.svh"
module dbcu_ctrl_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  dbcu_pkg::tick_t     tick,
  input  dbcu_pkg::cfg_regs_t cfg,
  output dbcu_pkg::result_t   result
);
  import dbcu_pkg::*;

  uplink_state_t  up_r;
  uplink_state_t  up_nxt;
  capture_state_t cap_r;
  capture_state_t cap_nxt;
  logic [7:0]     last_rx_r;
  logic [7:0]     last_rx_nxt;
  logic           send_idx_r;
  logic           send_idx_nxt;
  logic           fill_idx_r;
  logic           fill_idx_nxt;
  logic [1:0]     flags_r;
  logic [1:0]     flags_mid;
  logic [1:0]     flags_nxt;

  send_kind_t     kind;
  logic           sbuf;
  logic [15:0]    hlen;
  logic           consume;
  logic           launch;
  logic           cbuf;
  logic [15:0]    img_len;
  logic           acked;

  assign img_len = {8'd0, cfg.image_cols} * {8'd0, cfg.image_rows};
  assign acked   = (last_rx_r == cfg.ack_code);

  always_comb begin
    up_nxt = up_r;
    case (up_r)
      UP_CONFIG: begin
        if (!tick.sensing_enable) begin
          up_nxt = UP_INIT;
        end else if (!tick.link_busy) begin
          up_nxt = UP_CONFIG_ACK;
        end
      end
      UP_CONFIG_ACK, UP_IMAGE_ACK: begin
        if (!tick.sensing_enable) begin
          up_nxt = UP_INIT;
        end else if (tick.rx_valid && !acked) begin
          up_nxt = up_r;
        end else if (!tick.link_busy && acked) begin
          up_nxt = (up_r == UP_CONFIG_ACK) ? UP_IMAGE : UP_SENT;
        end
      end
      UP_IMAGE: begin
        if (!tick.sensing_enable) begin
          up_nxt = UP_INIT;
        end else if (!tick.link_busy && (|flags_r)) begin
          up_nxt = UP_IMAGE_ACK;
        end
      end
      UP_SENT: begin
        if (!tick.link_busy) begin
          up_nxt = UP_IMAGE;
        end
      end
      default: up_nxt = tick.sensing_enable ? UP_CONFIG : UP_INIT;
    endcase
  end

  always_comb begin
    kind         = SEND_NONE;
    sbuf         = 1'b0;
    hlen         = 16'd0;
    consume      = 1'b0;
    last_rx_nxt  = last_rx_r;
    send_idx_nxt = send_idx_r;
    flags_mid    = flags_r;
    case (up_r)
      UP_CONFIG: begin
        if (tick.sensing_enable && !tick.link_busy) begin
          kind = SEND_CFG_HDR;
          hlen = {8'd0, cfg.body_len};
        end
      end
      UP_CONFIG_ACK, UP_IMAGE_ACK: begin
        if (tick.sensing_enable) begin
          if (tick.rx_valid && !acked) begin
            last_rx_nxt = tick.rx_byte;
            consume     = 1'b1;
          end else if (!tick.link_busy && acked) begin
            if (up_r == UP_CONFIG_ACK) begin
              kind = SEND_CFG_BODY;
            end else begin
              kind        = SEND_IMG_DATA;
              sbuf        = send_idx_r;
              last_rx_nxt = 8'd0;
            end
          end
        end
      end
      UP_IMAGE: begin
        if (tick.sensing_enable && !tick.link_busy && (|flags_r)) begin
          send_idx_nxt = !flags_r[0];
          kind         = SEND_IMG_HDR;
          sbuf         = !flags_r[0];
          hlen         = img_len;
        end
      end
      UP_SENT: begin
        if (!tick.link_busy) begin
          flags_mid[send_idx_r] = 1'b0;
        end
      end
      default: kind = SEND_NONE;
    endcase
  end

  always_comb begin
    cap_nxt = cap_r;
    case (cap_r)
      CAP_IDLE: begin
        if (!tick.sensing_enable) begin
          cap_nxt = CAP_INACTIVE;
        end else if (!(&flags_mid)) begin
          cap_nxt = CAP_CAPTURING;
        end
      end
      CAP_CAPTURING: begin
        if (!tick.sensing_enable) begin
          cap_nxt = CAP_INACTIVE;
        end else if (tick.capture_done) begin
          cap_nxt = CAP_IDLE;
        end
      end
      default: cap_nxt = tick.sensing_enable ? CAP_IDLE : CAP_INACTIVE;
    endcase
  end

  always_comb begin
    launch       = 1'b0;
    cbuf         = 1'b0;
    fill_idx_nxt = fill_idx_r;
    flags_nxt    = flags_mid;
    case (cap_r)
      CAP_IDLE: begin
        if (tick.sensing_enable && !(&flags_mid)) begin
          fill_idx_nxt = flags_mid[0];
          launch       = 1'b1;
          cbuf         = flags_mid[0];
        end
      end
      CAP_CAPTURING: begin
        if (tick.sensing_enable && tick.capture_done) begin
          flags_nxt[fill_idx_r] = 1'b1;
        end
      end
      default: launch = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_r       <= UP_INIT;
      cap_r      <= CAP_INACTIVE;
      last_rx_r  <= 8'd0;
      send_idx_r <= 1'b0;
      fill_idx_r <= 1'b0;
      flags_r    <= 2'b00;
    end else if (step) begin
      up_r       <= up_nxt;
      cap_r      <= cap_nxt;
      last_rx_r  <= last_rx_nxt;
      send_idx_r <= send_idx_nxt;
      fill_idx_r <= fill_idx_nxt;
      flags_r    <= flags_nxt;
    end
  end

  always_comb begin
    result.send_kind      = kind;
    result.send_buffer    = sbuf;
    result.header_length  = hlen;
    result.rx_consume     = consume;
    result.launch_capture = launch;
    result.capture_buffer = cbuf;
    result.uplink_phase   = up_nxt;
    result.capture_phase  = cap_nxt;
    result.buffers_full   = flags_nxt;
  end

  `DBCU_ASSERT_NOW(a_launch_free, step && launch, !flags_mid[cbuf] && cap_nxt == CAP_CAPTURING, "capture launched into a full buffer")
  `DBCU_ASSERT_NEXT(a_data_clears_ack, step && kind == SEND_IMG_DATA, last_rx_r == 8'd0, "stored byte not cleared after image data")
  `DBCU_ASSERT_NOW(a_consume_valid, step && consume, tick.rx_valid && up_nxt == up_r && !acked, "byte consumed without a valid byte")

endmodule

// ----- sv/dbcu_out_stage.sv -----
// Result register that holds one beat until the downstream side takes it.
module dbcu_out_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              tick_valid,
  input  dbcu_pkg::result_t result,
  input  logic              out_stall,
  output logic              advance,
  output logic              out_valid,
  output dbcu_pkg::result_t out_result
);
  import dbcu_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t result_r;

  assign advance = !valid_r || !out_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && tick_valid) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

// ----- sv/double_buffer_capture_uplink_ctrl.sv -----
// Top level of the double-buffer capture and uplink controller.
//
// Channel   Direction  Handshake            Beat
// in_       input      in_valid / in_stall  one control tick
// out_      output     out_valid/out_stall  one result per tick
// cfg_      input      cfg_wr_en            one register write
//
// A beat is registered in the input register when accepted and its result in the
// result register when it advances; one beat per cycle while out_stall is low.
// Both state machines update in the cycle a tick moves into the result register.
// Reset is synchronous; it clears the controller state and the valid flags.
// A stalled result holds both registers; the input register takes one more
// beat only while it is empty.
module double_buffer_capture_uplink_ctrl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_wr_en,
  input  logic [dbcu_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dbcu_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_sensing_enable,
  input  logic                           in_link_busy,
  input  logic                           in_rx_valid,
  input  logic [7:0]                     in_rx_byte,
  input  logic                           in_capture_done,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     out_send_kind,
  output logic                           out_send_buffer,
  output logic [15:0]                    out_header_length,
  output logic                           out_rx_consume,
  output logic                           out_launch_capture,
  output logic                           out_capture_buffer,
  output logic [2:0]                     out_uplink_phase,
  output logic [1:0]                     out_capture_phase,
  output logic [1:0]                     out_buffers_full
);
  import dbcu_pkg::*;

  cfg_regs_t cfg;
  tick_t     in_tick;
  tick_t     tick;
  logic      tick_valid;
  logic      advance;
  logic      step;
  result_t   result;
  result_t   out_result;

  assign in_tick.sensing_enable = in_sensing_enable;
  assign in_tick.link_busy      = in_link_busy;
  assign in_tick.rx_valid       = in_rx_valid;
  assign in_tick.rx_byte        = in_rx_byte;
  assign in_tick.capture_done   = in_capture_done;

  assign step = tick_valid && advance;

  dbcu_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dbcu_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_tick    (in_tick),
    .advance    (advance),
    .tick_valid (tick_valid),
    .tick       (tick)
  );

  dbcu_ctrl_core u_ctrl_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .tick   (tick),
    .cfg    (cfg),
    .result (result)
  );

  dbcu_out_stage u_out_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_valid (tick_valid),
    .result     (result),
    .out_stall  (out_stall),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_result (out_result)
  );

  assign out_send_kind      = out_result.send_kind;
  assign out_send_buffer    = out_result.send_buffer;
  assign out_header_length  = out_result.header_length;
  assign out_rx_consume     = out_result.rx_consume;
  assign out_launch_capture = out_result.launch_capture;
  assign out_capture_buffer = out_result.capture_buffer;
  assign out_uplink_phase   = out_result.uplink_phase;
  assign out_capture_phase  = out_result.capture_phase;
  assign out_buffers_full   = out_result.buffers_full;

endmodule

// ----- bench/double_buffer_capture_uplink_ctrl_test.sv -----
// Self-checking testbench for the double-buffer capture and uplink controller.
`timescale 1ns / 1ps

module double_buffer_capture_uplink_ctrl_test;
  import dbcu_pkg::*;

  localparam int HOLD_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int PHASE_ITEMS    = 150;

  typedef enum int {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_PERIODIC} sink_mode_t;

  class uplink_tracker;
    uplink_state_t  up_st;
    capture_state_t cap_st;
    logic [7:0]     held_rx;
    logic           send_idx;
    logic           fill_idx;
    logic [1:0]     full;
    cfg_regs_t      regs;
    result_t        expected_results[$];
    int             errors;
    int             ticks;
    int             results_checked;
    int             images_sent;
    int             captures;
    int             acks_passed;

    function new();
      up_st    = UP_INIT;
      cap_st   = CAP_INACTIVE;
      held_rx  = '0;
      send_idx = 1'b0;
      fill_idx = 1'b0;
      full     = '0;
      regs     = {ACK_CODE_RST, IMAGE_COLS_RST, IMAGE_ROWS_RST, BODY_LEN_RST};
      errors = 0;
      ticks = 0;
      results_checked = 0;
      images_sent = 0;
      captures = 0;
      acks_passed = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [7:0] value);
      case (idx)
        CFG_ACK_CODE:   regs.ack_code = value;
        CFG_IMAGE_COLS: regs.image_cols = value;
        CFG_IMAGE_ROWS: regs.image_rows = value;
        CFG_BODY_LEN:   regs.body_len = value;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    // The uplink machine goes first; the capture machine sees its buffer flags.
    function void note_tick(tick_t t);
      result_t     r;
      logic [15:0] frame_len;
      r = '0;
      frame_len = 16'(regs.image_cols) * 16'(regs.image_rows);
      ticks++;
      case (up_st)
        UP_CONFIG: begin
          if (!t.sensing_enable) begin
            up_st = UP_INIT;
          end else if (!t.link_busy) begin
            r.send_kind = SEND_CFG_HDR;
            r.header_length = 16'(regs.body_len);
            up_st = UP_CONFIG_ACK;
          end
        end
        UP_CONFIG_ACK, UP_IMAGE_ACK: begin
          if (!t.sensing_enable) begin
            up_st = UP_INIT;
          end else if (t.rx_valid && held_rx != regs.ack_code) begin
            held_rx = t.rx_byte;
            r.rx_consume = 1'b1;
          end else if (!t.link_busy && held_rx == regs.ack_code) begin
            acks_passed++;
            if (up_st == UP_CONFIG_ACK) begin
              r.send_kind = SEND_CFG_BODY;
              up_st = UP_IMAGE;
            end else begin
              r.send_kind = SEND_IMG_DATA;
              r.send_buffer = send_idx;
              held_rx = '0;
              up_st = UP_SENT;
              images_sent++;
            end
          end
        end
        UP_IMAGE: begin
          if (!t.sensing_enable) begin
            up_st = UP_INIT;
          end else if (!t.link_busy && full != 2'b00) begin
            send_idx = full[0] ? 1'b0 : 1'b1;
            r.send_kind = SEND_IMG_HDR;
            r.send_buffer = send_idx;
            r.header_length = frame_len;
            up_st = UP_IMAGE_ACK;
          end
        end
        UP_SENT: begin
          if (!t.link_busy) begin
            full[send_idx] = 1'b0;
            up_st = UP_IMAGE;
          end
        end
        default: up_st = t.sensing_enable ? UP_CONFIG : UP_INIT;
      endcase
      case (cap_st)
        CAP_IDLE: begin
          if (!t.sensing_enable) begin
            cap_st = CAP_INACTIVE;
          end else if (full != 2'b11) begin
            fill_idx = full[0];
            r.launch_capture = 1'b1;
            r.capture_buffer = fill_idx;
            cap_st = CAP_CAPTURING;
            captures++;
          end
        end
        CAP_CAPTURING: begin
          if (!t.sensing_enable) begin
            cap_st = CAP_INACTIVE;
          end else if (t.capture_done) begin
            full[fill_idx] = 1'b1;
            cap_st = CAP_IDLE;
          end
        end
        default: cap_st = t.sensing_enable ? CAP_IDLE : CAP_INACTIVE;
      endcase
      r.uplink_phase = up_st;
      r.capture_phase = cap_st;
      r.buffers_full = full;
      expected_results.push_back(r);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        errors++;
        if (errors <= 40)
          $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: result beat with no tick pending, actual %h", $time, got);
        return;
      end
      want = expected_results.pop_front();
      results_checked++;
      compare_field("send_kind", 16'(want.send_kind), 16'(got.send_kind));
      compare_field("send_buffer", 16'(want.send_buffer), 16'(got.send_buffer));
      compare_field("header_length", want.header_length, got.header_length);
      compare_field("rx_consume", 16'(want.rx_consume), 16'(got.rx_consume));
      compare_field("launch_capture", 16'(want.launch_capture), 16'(got.launch_capture));
      compare_field("capture_buffer", 16'(want.capture_buffer), 16'(got.capture_buffer));
      compare_field("uplink_phase", 16'(want.uplink_phase), 16'(got.uplink_phase));
      compare_field("capture_phase", 16'(want.capture_phase), 16'(got.capture_phase));
      compare_field("buffers_full", 16'(want.buffers_full), 16'(got.buffers_full));
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  logic                 in_sensing_enable;
  logic                 in_link_busy;
  logic                 in_rx_valid;
  logic [7:0]           in_rx_byte;
  logic                 in_capture_done;
  logic                 out_valid;
  logic                 out_stall;
  logic [2:0]           out_send_kind;
  logic                 out_send_buffer;
  logic [15:0]          out_header_length;
  logic                 out_rx_consume;
  logic                 out_launch_capture;
  logic                 out_capture_buffer;
  logic [2:0]           out_uplink_phase;
  logic [1:0]           out_capture_phase;
  logic [1:0]           out_buffers_full;

  uplink_tracker tracker = new();
  int  quiet_cycles = 0;
  int  burst_left = 0;
  bit  hold_request = 1'b0;

  double_buffer_capture_uplink_ctrl i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sensing_enable (in_sensing_enable),
    .in_link_busy      (in_link_busy),
    .in_rx_valid       (in_rx_valid),
    .in_rx_byte        (in_rx_byte),
    .in_capture_done   (in_capture_done),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_send_kind     (out_send_kind),
    .out_send_buffer   (out_send_buffer),
    .out_header_length (out_header_length),
    .out_rx_consume    (out_rx_consume),
    .out_launch_capture(out_launch_capture),
    .out_capture_buffer(out_capture_buffer),
    .out_uplink_phase  (out_uplink_phase),
    .out_capture_phase (out_capture_phase),
    .out_buffers_full  (out_buffers_full)
  );

  initial clk = 1'b0;
  always #2 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        tracker.note_tick({in_sensing_enable, in_link_busy, in_rx_valid, in_rx_byte,
                           in_capture_done});
      if (out_valid && !out_stall)
        tracker.check_result({out_send_kind, out_send_buffer, out_header_length,
                              out_rx_consume, out_launch_capture, out_capture_buffer,
                              out_uplink_phase, out_capture_phase, out_buffers_full});
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // The receiver switches between stall patterns and takes one long hold-off
  // on request so that the block backs up into its input.
  initial begin
    sink_mode_t mode;
    int         mode_left;
    mode = SINK_OPEN;
    mode_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (mode_left == 0) begin
        mode = sink_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(8, 40);
      end
      mode_left--;
      case (mode)
        SINK_OPEN:  out_stall = 1'b0;
        SINK_LIGHT: out_stall = ($urandom_range(0, 99) < 30);
        SINK_HEAVY: out_stall = ($urandom_range(0, 99) < 70);
        default:    out_stall = (mode_left % 3 == 0);
      endcase
    end
  end

  function automatic tick_t make_tick(bit en, bit busy, bit rxv, logic [7:0] rxb, bit done);
    tick_t t;
    t.sensing_enable = en;
    t.link_busy = busy;
    t.rx_valid = rxv;
    t.rx_byte = rxb;
    t.capture_done = done;
    return t;
  endfunction

  // Mostly enabled ticks with the ack byte offered often, so that whole
  // config and image exchanges complete; the rest is noise.
  function automatic tick_t random_tick();
    logic [7:0] rxb;
    rxb = $urandom_range(0, 1) ? tracker.regs.ack_code : 8'($urandom);
    return make_tick($urandom_range(0, 99) >= 3, $urandom_range(0, 99) < 35,
                     1'($urandom_range(0, 1)), rxb, $urandom_range(0, 99) < 30);
  endfunction

  task automatic offer_tick(input tick_t t);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_sensing_enable = t.sensing_enable;
    in_link_busy = t.link_busy;
    in_rx_valid = t.rx_valid;
    in_rx_byte = t.rx_byte;
    in_capture_done = t.capture_done;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [7:0] value);
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    tracker.set_reg(idx, value);
  endtask

  task automatic apply_setting(input logic [7:0] ack, input logic [7:0] cols,
                               input logic [7:0] rows, input logic [7:0] body);
    write_reg(CFG_ACK_CODE, ack);
    write_reg(CFG_IMAGE_COLS, cols);
    write_reg(CFG_IMAGE_ROWS, rows);
    write_reg(CFG_BODY_LEN, body);
  endtask

  task automatic run_random(input int count);
    for (int k = 0; k < count; k++) begin
      if (k == 30)
        hold_request = 1'b1;
      offer_tick(random_tick());
    end
    settle();
  endtask

  initial begin
    tick_t directed[$];
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_sensing_enable = 1'b0;
    in_link_busy = 1'b0;
    in_rx_valid = 1'b0;
    in_rx_byte = '0;
    in_capture_done = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // A full walk through config and two image exchanges at reset settings,
    // including a stale ack after config, an ignored byte while acked and a
    // send that completes after sensing is switched off.
    directed.push_back(make_tick(0, 0, 0, 8'h00, 0));
    directed.push_back(make_tick(1, 1, 0, 8'h00, 0));
    directed.push_back(make_tick(1, 1, 0, 8'h00, 0));
    directed.push_back(make_tick(1, 0, 0, 8'h00, 0));
    directed.push_back(make_tick(1, 0, 1, 8'hFF, 1));
    directed.push_back(make_tick(1, 0, 1, 8'h00, 0));
    directed.push_back(make_tick(1, 1, 1, 8'h06, 1));
    directed.push_back(make_tick(1, 1, 1, 8'hFF, 0));
    directed.push_back(make_tick(1, 0, 0, 8'h00, 0));
    directed.push_back(make_tick(1, 0, 0, 8'h00, 0));
    directed.push_back(make_tick(1, 0, 0, 8'h00, 0));
    directed.push_back(make_tick(1, 1, 0, 8'h00, 0));
    directed.push_back(make_tick(0, 0, 0, 8'h00, 0));
    directed.push_back(make_tick(1, 0, 0, 8'h00, 0));
    directed.push_back(make_tick(1, 0, 1, 8'h06, 0));
    directed.push_back(make_tick(1, 0, 0, 8'h00, 0));
    directed.push_back(make_tick(1, 0, 0, 8'h00, 1));
    directed.push_back(make_tick(0, 1, 1, 8'h06, 1));
    directed.push_back(make_tick(1, 1, 1, 8'h5A, 1));
    directed.push_back(make_tick(1, 0, 1, 8'hA5, 1));
    foreach (directed[k])
      offer_tick(directed[k]);
    settle();

    run_random(PHASE_ITEMS);
    apply_setting(8'h00, 8'hFF, 8'hFF, 8'hFF);
    run_random(PHASE_ITEMS);
    apply_setting(8'hFF, 8'h01, 8'h01, 8'h00);
    run_random(PHASE_ITEMS);
    apply_setting(8'($urandom), 8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                  8'($urandom));
    run_random(PHASE_ITEMS);

    repeat (10) @(posedge clk);
    if (tracker.pending() != 0)
      tracker.errors += tracker.pending();
    $display("Covered %0d ticks under four register settings with long output hold-offs.",
             tracker.ticks);
    $display("Saw %0d images sent, %0d captures started and %0d acks honored.",
             tracker.images_sent, tracker.captures, tracker.acks_passed);
    if (tracker.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
